// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the byte pattern matcher, included by byte_pattern_matcher_core.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`endif

// ===== rtl/bpm_pkg.sv =====
// Package for the byte pattern matcher: field widths, opcodes and the cell control bundle.
// Used by bpm_cell, bpm_out_skid and byte_pattern_matcher_core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpm_pkg;

   // Defaults for the top level parameters
   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int OFFSET_BITS_DEFAULT = 32;

   // Fixed widths of the request, response and register fields
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int RESULT_W = 32;

   // Request opcodes; the remaining code is ignored
   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_SCAN    = 2'd1,
      OP_RESTART = 2'd2
   } opcode_type;

   // Broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic               scan;      // stream byte accepted this cycle
      logic               load;      // pattern byte accepted this cycle
      logic               restart;   // restart accepted this cycle
      logic [INDEX_W-1:0] index;     // pattern position for a load
      logic [BYTE_W-1:0]  data_byte; // pattern byte or stream byte
      logic [LEN_W-1:0]   length;    // pattern length in use
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/bpm_cell.sv =====
// One position of the shift-and chain: a pattern byte and its partial-match bit.
// Depends on bpm_pkg for the control bundle and field widths.
`timescale 1ns / 1ps
`default_nettype none

module bpm_cell
   import bpm_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          match_in,
   output logic               match_out,
   output logic               hit
);

   logic [BYTE_W-1:0] pattern_ff;
   logic              match_ff;
   logic              match_in_next;
   logic              cell_used;
   logic              cell_last;
   logic              byte_equal;
   logic              write_here;

   // Position state relative to the current length
   assign cell_used  = (32'(ctrl.length) > 32'(CELL_INDEX));
   assign cell_last  = (32'(ctrl.length) == 32'(CELL_INDEX + 1));
   assign byte_equal = (pattern_ff == ctrl.data_byte);
   assign write_here = ctrl.load && (32'(ctrl.index) == 32'(CELL_INDEX));

   // Shift the neighbor's bit in and keep it only on a byte match in a used cell; restart clears it
   always_comb begin
      match_in_next = match_ff;
      if (ctrl.restart) begin
         match_in_next = 1'b0;
      end else if (ctrl.scan) begin
         match_in_next = match_in && cell_used && byte_equal;
      end
   end

   // Hold the partial-match bit
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in_next;
      end
   end

   // Load the pattern byte
   always_ff @(posedge clock) begin
      if (write_here) begin
         pattern_ff <= ctrl.data_byte;
      end
   end

   assign match_out = match_ff;
   assign hit       = ctrl.scan && cell_last && match_in_next;

endmodule

`default_nettype wire

// ===== rtl/bpm_out_skid.sv =====
// Two-entry response buffer: an output register and a skid register behind it.
// Depends on bpm_pkg for the response width.
`timescale 1ns / 1ps
`default_nettype none

module bpm_out_skid
   import bpm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [RESULT_W-1:0] push_start,
   input  wire logic [RESULT_W-1:0] push_count,
   output logic                     full,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [RESULT_W-1:0]      rsp_match_start,
   output logic [RESULT_W-1:0]      rsp_match_count
);

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [RESULT_W-1:0] out_start_ff;
   logic [RESULT_W-1:0] out_start_in;
   logic [RESULT_W-1:0] out_count_ff;
   logic [RESULT_W-1:0] out_count_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   logic [RESULT_W-1:0] skid_start_ff;
   logic [RESULT_W-1:0] skid_start_in;
   logic [RESULT_W-1:0] skid_count_ff;
   logic [RESULT_W-1:0] skid_count_in;
   logic                pop;

   assign pop = out_valid_ff && !rsp_stall;

   // Advance the skid entry or a new response into the output register, or park a new response in the skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_start_in  = out_start_ff;
      out_count_in  = out_count_ff;
      skid_valid_in = skid_valid_ff;
      skid_start_in = skid_start_ff;
      skid_count_in = skid_count_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_start_in  = skid_start_ff;
            out_count_in  = skid_count_ff;
            skid_valid_in = push;
            skid_start_in = push_start;
            skid_count_in = push_count;
         end else begin
            out_valid_in = push;
            out_start_in = push_start;
            out_count_in = push_count;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_start_in = push_start;
         skid_count_in = push_count;
      end
   end

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      out_start_ff  <= out_start_in;
      out_count_ff  <= out_count_in;
      skid_start_ff <= skid_start_in;
      skid_count_ff <= skid_count_in;
   end

   assign full            = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_match_start = out_start_ff;
   assign rsp_match_count = out_count_ff;

endmodule

`default_nettype wire

// ===== rtl/byte_pattern_matcher_core.sv =====
// Byte pattern matcher: takes one request per cycle while req_stall is low and reports
// every occurrence of the loaded pattern in the byte stream, overlapping ones included.
// Each request is done in the cycle it is accepted: a row of PATTERN_MAX cells updates all
// partial-match bits at once, and a response is registered for the byte that completes a
// match. Responses pass through a two-entry buffer; req_stall rises only
// when both entries are held by a stalled response side. Load pattern bytes and write
// csr_wr_data (the length, 0 ignored, saturated to PATTERN_MAX) before scanning; positions
// below the length must have been loaded. match_start is the offset of the first byte of
// the occurrence, counted modulo 2^OFFSET_BITS since the last restart.
// Depends on bpm_pkg, bpm_cell, bpm_out_skid and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module byte_pattern_matcher_core
   import bpm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [INDEX_W-1:0]  req_pattern_index,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [RESULT_W-1:0]      rsp_match_start,
   output logic [RESULT_W-1:0]      rsp_match_count,
   // length register
   input  wire logic                csr_wr_en,
   input  wire logic [LEN_W-1:0]    csr_wr_data
);

   logic                          req_accept;
   cell_ctrl_type                 ctrl;
   logic [LEN_W-1:0]              length_ff;
   logic [LEN_W-1:0]              length_in;
   logic [OFFSET_BITS-1:0]        offset_ff;
   logic [OFFSET_BITS-1:0]        offset_in;
   logic [RESULT_W-1:0]           count_ff;
   logic [RESULT_W-1:0]           count_in;
   logic [PATTERN_MAX:0]          chain;
   logic [PATTERN_MAX-1:0]        hit_vec;
   logic                          any_hit;
   logic [LEN_W-1:0]              last_pos;
   logic [OFFSET_BITS-1:0]        start_full;
   logic [OFFSET_BITS+RESULT_W-1:0] start_ext;
   logic                          skid_full;

   assign req_accept = req_valid && !req_stall;

   // Broadcast the accepted request to the cells
   always_comb begin
      ctrl.scan      = req_accept && (req_opcode == OP_SCAN);
      ctrl.load      = req_accept && (req_opcode == OP_LOAD);
      ctrl.restart   = req_accept && (req_opcode == OP_RESTART);
      ctrl.index     = req_pattern_index;
      ctrl.data_byte = req_data_byte;
      ctrl.length    = length_ff;
   end

   // Chain of cells, bit zero fed with a constant one
   assign chain[0] = 1'b1;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      bpm_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .match_in  (chain[g]),
         .match_out (chain[g+1]),
         .hit       (hit_vec[g])
      );
   end

   assign any_hit = |hit_vec;

   // Start offset of the occurrence ending at the current byte
   assign last_pos   = length_ff - LEN_W'(1);
   assign start_full = offset_ff - {{(OFFSET_BITS-LEN_W){1'b0}}, last_pos};
   assign start_ext  = {{RESULT_W{1'b0}}, start_full};

   // Length register: drop zero, saturate to the cell count
   always_comb begin
      length_in = length_ff;
      if (csr_wr_en && (csr_wr_data != '0)) begin
         if (32'(csr_wr_data) > 32'(PATTERN_MAX)) begin
            length_in = LEN_W'(PATTERN_MAX);
         end else begin
            length_in = csr_wr_data;
         end
      end
   end

   // Advance the stream offset and the match count, or clear both on a restart
   always_comb begin
      offset_in = offset_ff;
      count_in  = count_ff;
      if (ctrl.restart) begin
         offset_in = '0;
         count_in  = '0;
      end else if (ctrl.scan) begin
         offset_in = offset_ff + OFFSET_BITS'(1);
         if (any_hit) begin
            count_in = count_ff + RESULT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         offset_ff <= '0;
         count_ff  <= '0;
      end else begin
         length_ff <= length_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   // Response buffer
   bpm_out_skid u_out_skid (
      .clock           (clock),
      .reset           (reset),
      .push            (any_hit),
      .push_start      (start_ext[RESULT_W-1:0]),
      .push_count      (count_in),
      .full            (skid_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_start (rsp_match_start),
      .rsp_match_count (rsp_match_count)
   );

   assign req_stall = skid_full;

   // Checks
   `ASSERT_ALWAYS(a_single_last_cell, $onehot0(hit_vec), "more than one cell reports a match")
   `ASSERT_PROP(a_hit_gives_response, any_hit |=> rsp_valid, "match lost before the output")
   `ASSERT_PROP(a_stall_means_pending, req_stall |-> rsp_valid, "stall without a waiting response")
   `ASSERT_PROP(a_restart, ctrl.restart |=> ({offset_ff, count_ff} == '0), "restart did not clear")

endmodule

`default_nettype wire

// ===== tb/sv/tb_byte_pattern_matcher_core.sv =====
// Self-checking testbench for byte_pattern_matcher_core: predicts every match report and
// compares it with the response channel under random request gaps and response stalls.
// Depends on bpm_pkg and byte_pattern_matcher_core.
`timescale 1ns / 1ps

module tb_byte_pattern_matcher_core;
   import bpm_pkg::*;

   localparam int PATTERN_MAX  = PATTERN_MAX_DEFAULT;
   localparam int SETTLE       = 6;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ROUNDS = 16;

   // Opcode that the block ignores
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Idle modes of either side
   localparam int IDLE_NONE  = 0;
   localparam int IDLE_FULL  = 1;
   localparam int IDLE_SPARSE = 2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [INDEX_W-1:0]  index;
      logic [BYTE_W-1:0]   data;
   } request_type;

   typedef struct packed {
      logic [RESULT_W-1:0] start;
      logic [RESULT_W-1:0] count;
   } match_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode        = OP_UNUSED;
   logic [INDEX_W-1:0]  req_pattern_index = '0;
   logic [BYTE_W-1:0]   req_data_byte     = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [RESULT_W-1:0] rsp_match_start;
   logic [RESULT_W-1:0] rsp_match_count;
   logic                csr_wr_en         = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data       = '0;

   byte_pattern_matcher_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pattern_index (req_pattern_index),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_start   (rsp_match_start),
      .rsp_match_count   (rsp_match_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state, mirrors the block
   logic [BYTE_W-1:0]      known_pattern [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] partial_bits;
   logic [31:0]            stream_pos;
   logic [RESULT_W-1:0]    found_total;
   logic [LEN_W-1:0]       active_len;
   match_type              pending_matches [$];

   // Stimulus generator state
   request_type            request_queue [$];
   logic [BYTE_W-1:0]      byte_plan [$];
   logic [BYTE_W-1:0]      gen_pattern [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] gen_written = '0;
   logic [LEN_W-1:0]       gen_len = LEN_W'(1);
   logic [BYTE_W-1:0]      alphabet [4];
   int                     alpha_n = 1;
   bit                     wide_bytes = 1'b0;

   // Handshake bookkeeping
   int send_mode = IDLE_NONE;
   int recv_mode = IDLE_NONE;
   int send_gap = 0;
   int hold_left = 0;
   bit req_loaded = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;

   // Length register rule: zero refused, large values saturate
   function automatic logic [LEN_W-1:0] next_length(input logic [LEN_W-1:0] cur,
                                                     input logic [LEN_W-1:0] value);
      if (value == 0)
         return cur;
      if (value > PATTERN_MAX)
         return LEN_W'(PATTERN_MAX);
      return value;
   endfunction

   function automatic int idle_draw(input int mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_FULL: return $urandom_range(0, 17);
         default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      if (wide_bytes)
         return BYTE_W'($urandom);
      return alphabet[$urandom_range(0, alpha_n - 1)];
   endfunction

   // Advance the shift-and state by one request and queue the match it reports
   task automatic predict_request(input logic [OPCODE_W-1:0] op,
                                  input logic [INDEX_W-1:0] idx,
                                  input logic [BYTE_W-1:0] data);
      logic [PATTERN_MAX-1:0] bits;
      logic [LEN_W-1:0]       last;
      match_type              hit;
      case (op)
         OP_LOAD: begin
            known_pattern[idx] = data;
         end
         OP_RESTART: begin
            partial_bits = '0;
            stream_pos   = '0;
            found_total  = '0;
         end
         OP_SCAN: begin
            bits = {partial_bits[PATTERN_MAX-2:0], 1'b1};
            for (int i = 0; i < PATTERN_MAX; i++)
               if (i >= active_len || known_pattern[i] != data)
                  bits[i] = 1'b0;
            partial_bits = bits;
            last = active_len - 1'b1;
            if (bits[last]) begin
               found_total = found_total + 1'b1;
               hit.start = stream_pos - last;
               hit.count = found_total;
               pending_matches.push_back(hit);
            end
            stream_pos = stream_pos + 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   // Monitor: check responses, track register writes and accepted requests
   always @(posedge clock) begin
      match_type want;
      if (reset) begin
         partial_bits = '0;
         stream_pos   = '0;
         found_total  = '0;
         active_len   = LEN_W'(1);
         pending_matches.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_matches.size() == 0) begin
               $error("response with no match expected: match_start %0d match_count %0d",
                      rsp_match_start, rsp_match_count);
               fail_count++;
            end else begin
               want = pending_matches.pop_front();
               if (rsp_match_start !== want.start) begin
                  $error("match_start expected %0d actual %0d", want.start, rsp_match_start);
                  fail_count++;
               end
               if (rsp_match_count !== want.count) begin
                  $error("match_count expected %0d actual %0d", want.count, rsp_match_count);
                  fail_count++;
               end
            end
            rsp_taken = 1'b1;
         end
         if (csr_wr_en)
            active_len = next_length(active_len, csr_wr_data);
         if (req_valid && !req_stall) begin
            predict_request(req_opcode, req_pattern_index, req_data_byte);
            req_taken = 1'b1;
         end
      end
   end

   // Driver: present queued requests, hold each until accepted, then draw a gap
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken  = 1'b0;
            req_loaded = 1'b0;
            send_gap   = idle_draw(send_mode);
         end
         if (!req_loaded) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               next_req = request_queue.pop_front();
               req_loaded = 1'b1;
               req_valid         <= 1'b1;
               req_opcode        <= next_req.opcode;
               req_pattern_index <= next_req.index;
               req_data_byte     <= next_req.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: draw a stall after each accepted response, and now and then while idle
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         hold_left = idle_draw(recv_mode);
      end else if (!rsp_valid && hold_left == 0 && $urandom_range(0, 15) == 0) begin
         hold_left = idle_draw(recv_mode);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] data);
      request_type item;
      item.opcode = op;
      item.index  = idx;
      item.data   = data;
      request_queue.push_back(item);
      if (op == OP_LOAD) begin
         gen_pattern[idx] = data;
         gen_written[idx] = 1'b1;
      end
   endtask

   // Wait until every request is taken and every match has come back, then settle
   task automatic drain_and_settle();
      while (request_queue.size() != 0 || req_loaded || pending_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gen_len = next_length(gen_len, value);
   endtask

   // Queue the next run of stream bytes: a pattern copy, a broken copy, a prefix or noise
   task automatic plan_bytes();
      int roll;
      int pos;
      int k;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         for (int i = 0; i < gen_len; i++)
            byte_plan.push_back(gen_pattern[i]);
      end else if (roll < 60) begin
         pos = $urandom_range(0, gen_len - 1);
         for (int i = 0; i < gen_len; i++)
            byte_plan.push_back((i == pos) ? pick_byte() : gen_pattern[i]);
      end else if (roll < 75) begin
         k = $urandom_range(1, gen_len);
         for (int i = 0; i < k; i++)
            byte_plan.push_back(gen_pattern[i]);
      end else begin
         repeat ($urandom_range(1, 3)) byte_plan.push_back(pick_byte());
      end
   endtask

   task automatic random_phase(input int n_items);
      int roll;
      // load every position in use that was never written
      for (int i = 0; i < gen_len; i++)
         if (!gen_written[i])
            push_item(OP_LOAD, INDEX_W'(i), pick_byte());
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            if (byte_plan.size() == 0)
               plan_bytes();
            push_item(OP_SCAN, INDEX_W'($urandom), byte_plan.pop_front());
         end else if (roll < 82) begin
            push_item(OP_LOAD, INDEX_W'($urandom), pick_byte());
         end else if (roll < 86) begin
            push_item(OP_RESTART, INDEX_W'($urandom), BYTE_W'($urandom));
         end else if (roll < 90) begin
            push_item(OP_UNUSED, INDEX_W'($urandom), BYTE_W'($urandom));
         end else begin
            push_item(OP_SCAN, INDEX_W'($urandom), BYTE_W'($urandom));
         end
      end
   endtask

   initial begin
      int value;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-byte pattern at the reset length, ignored opcode, restart
      send_mode = IDLE_FULL;
      recv_mode = IDLE_FULL;
      push_item(OP_LOAD, 6'd0, 8'hA5);
      push_item(OP_SCAN, 6'd0, 8'hA5);
      push_item(OP_SCAN, 6'd63, 8'h5A);
      push_item(OP_SCAN, 6'd0, 8'hA5);
      push_item(OP_UNUSED, 6'd63, 8'hFF);
      push_item(OP_RESTART, 6'd21, 8'h00);
      push_item(OP_SCAN, 6'd0, 8'hA5);
      push_item(OP_LOAD, 6'd63, 8'hFF);
      push_item(OP_LOAD, 6'd1, 8'h00);
      push_item(OP_LOAD, 6'd2, 8'h00);
      drain_and_settle();

      // Zero length is refused, so the single-byte pattern still matches
      write_length(7'd0);
      push_item(OP_SCAN, 6'd0, 8'hA5);
      drain_and_settle();

      // Overlapping occurrences of a three-byte run, broken once
      send_mode = IDLE_NONE;
      recv_mode = IDLE_SPARSE;
      write_length(7'd3);
      push_item(OP_LOAD, 6'd0, 8'h00);
      repeat (5) push_item(OP_SCAN, 6'd0, 8'h00);
      push_item(OP_SCAN, 6'd0, 8'hFF);
      repeat (3) push_item(OP_SCAN, 6'd0, 8'h00);
      drain_and_settle();

      // Random rounds, each behind a fresh length setting
      for (int ph = 0; ph < RANDOM_ROUNDS; ph++) begin
         case (ph)
            0: value = 127;
            1: value = 0;
            2: value = 64;
            3: value = 65;
            4: value = 1;
            default: begin
               value = $urandom_range(0, 99);
               if (value < 60)
                  value = $urandom_range(1, 6);
               else if (value < 85)
                  value = $urandom_range(7, 20);
               else
                  value = $urandom_range(21, 127);
            end
         endcase
         send_mode = (ph % 4 == 1) ? IDLE_NONE : $urandom_range(0, 2);
         recv_mode = (ph % 4 == 1) ? IDLE_NONE : $urandom_range(0, 2);
         wide_bytes = ($urandom_range(0, 3) == 0);
         alpha_n = $urandom_range(1, 4);
         for (int k = 0; k < 4; k++)
            alphabet[k] = BYTE_W'($urandom);
         byte_plan.delete();
         write_length(LEN_W'(value));
         random_phase(64 + gen_len);
         drain_and_settle();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpm_pkg.sv
rtl/bpm_cell.sv
rtl/bpm_out_skid.sv
rtl/byte_pattern_matcher_core.sv
tb/sv/tb_byte_pattern_matcher_core.sv
